>>> hw/rtl/sts_pkg.sv
// Shared types and constants for the sorted key table search block.
package sts_pkg;

  localparam int WORD_W  = 32;
  localparam int KEY_W   = 4 * WORD_W;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register index of entry_count, taken from paddr[2].
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Request types.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINAL
  } state_t;

  // Result of comparing the stored entry against the search key.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // One lookup result as presented to the output registers.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

>>> hw/rtl/sts_key_mem.sv
// Key table memory: one write port, one registered read port.
module sts_key_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [sts_pkg::KEY_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [sts_pkg::KEY_W-1:0] rd_data
);

  logic [sts_pkg::KEY_W-1:0] mem [DEPTH];
  logic [sts_pkg::KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/sts_key_cmp.sv
// Shared 128-bit key comparator, word 0 most significant.
module sts_key_cmp (
  input  logic [sts_pkg::KEY_W-1:0] entry,
  input  logic [sts_pkg::KEY_W-1:0] key,
  output sts_pkg::cmp_res_t         res
);

  // Word 0 sits in the top bits, so an unsigned compare of the packed
  // vectors is the lexicographic order over the four words.
  always_comb begin
    res.lt = entry < key;
    res.eq = entry == key;
  end

endmodule

>>> hw/rtl/sts_search_ctrl.sv
// Binary search sequencer: bound registers, probe address and result.
module sts_search_ctrl #(
  parameter int AW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_lookup,
  input  logic [sts_pkg::CNT_W-1:0] count,
  input  sts_pkg::cmp_res_t         cmp,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output logic                      busy,
  output sts_pkg::res_t             res
);

  sts_pkg::state_t state_r, state_nxt;

  // l1 is the low bound plus one; the search ends when it meets high.
  logic [sts_pkg::CNT_W-1:0] l1_r, high_r, mid_r;
  logic [sts_pkg::CNT_W-1:0] l1_nxt, high_nxt, mid_nxt;
  logic [sts_pkg::CNT_W:0]   sum;
  logic                      last;
  logic                      found;
  sts_pkg::res_t             res_r;

  always_comb begin
    case (state_r)
      sts_pkg::S_IDLE: begin
        l1_nxt   = '0;
        high_nxt = count;
      end
      sts_pkg::S_SEARCH: begin
        if (cmp.lt) begin
          l1_nxt   = mid_r + sts_pkg::CNT_W'(1);
          high_nxt = high_r;
        end else begin
          l1_nxt   = l1_r;
          high_nxt = mid_r;
        end
      end
      default: begin
        l1_nxt   = l1_r;
        high_nxt = high_r;
      end
    endcase
    sum     = {1'b0, l1_nxt} + {1'b0, high_nxt} - (sts_pkg::CNT_W+1)'(1);
    mid_nxt = sum[sts_pkg::CNT_W:1];
    last    = l1_nxt == high_nxt;
  end

  always_comb begin
    case (state_r)
      sts_pkg::S_IDLE: begin
        if (start_lookup) begin
          state_nxt = last ? sts_pkg::S_FINAL : sts_pkg::S_SEARCH;
        end else begin
          state_nxt = sts_pkg::S_IDLE;
        end
      end
      sts_pkg::S_SEARCH: state_nxt = last ? sts_pkg::S_FINAL : sts_pkg::S_SEARCH;
      sts_pkg::S_FINAL:  state_nxt = sts_pkg::S_IDLE;
      default:           state_nxt = sts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    busy  = 1'b1;
    case (state_r)
      sts_pkg::S_IDLE: begin
        rd_en = start_lookup;
        busy  = 1'b0;
      end
      sts_pkg::S_SEARCH: rd_en = 1'b1;
      sts_pkg::S_FINAL:  rd_en = 1'b0;
      default:           busy  = 1'b0;
    endcase
    // The closing read fetches the bound itself; a bound at the count is
    // never compared, so address zero keeps the read inside the table.
    if (last) begin
      rd_addr = (high_nxt < count) ? AW'(high_nxt) : '0;
    end else begin
      rd_addr = AW'(mid_nxt);
    end
    found = (state_r == sts_pkg::S_FINAL) && (high_r < count) && cmp.eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sts_pkg::S_IDLE;
      res_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      res_r.valid <= state_r == sts_pkg::S_FINAL;
      if (state_r == sts_pkg::S_FINAL) begin
        res_r.found <= found;
        res_r.index <= found ? high_r[sts_pkg::IDX_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      l1_r   <= l1_nxt;
      high_r <= high_nxt;
      mid_r  <= mid_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> hw/rtl/sorted_table_key_search.sv
// Top level of the sorted key table search block with its register port.
//
// A load request writes one 128-bit entry and gives no result; busy stays
// low. A lookup request runs a lower-bound binary search over the first
// entry_count entries, one probe per clock through the single registered
// read port of the key table and the one shared key comparator, followed
// by one more read and compare of the entry at the bound. busy is high
// while probe results are compared and through the final compare; there
// are at most floor(log2(entry_count)) + 1 probes, so 11 for a full
// 1024-entry table, and zero for an empty table. The result appears on
// out_found and out_match_index, marked by out_valid for exactly one cycle,
// in the same cycle that busy falls; the receiver cannot hold it off, and a new request may
// be accepted in that same cycle. The table has no reset: every entry below
// entry_count must be loaded before a lookup. entry_count resets to zero and
// saturates at TABLE_DEPTH; write it only while the block is idle.
module sorted_table_key_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [sts_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [sts_pkg::WORD_W-1:0]   in_key_word0,
  input  logic [sts_pkg::WORD_W-1:0]   in_key_word1,
  input  logic [sts_pkg::WORD_W-1:0]   in_key_word2,
  input  logic [sts_pkg::WORD_W-1:0]   in_key_word3,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [sts_pkg::IDX_W-1:0]    out_match_index,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sts_pkg::APB_AW-1:0]   paddr,
  input  logic [sts_pkg::APB_DW-1:0]   pwdata,
  output logic [sts_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [sts_pkg::CNT_W-1:0] count_r;
  logic [sts_pkg::KEY_W-1:0] key_r;
  logic [sts_pkg::KEY_W-1:0] in_key;
  logic [sts_pkg::KEY_W-1:0] rd_data;
  logic [AW-1:0]             rd_addr;
  logic                      rd_en;
  logic                      accept;
  logic                      load_wr;
  logic                      start_lookup;
  logic                      cfg_wr;
  sts_pkg::cmp_res_t         cmp;
  sts_pkg::res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr && paddr[2] == sts_pkg::REG_ENTRY_COUNT) begin
      if (32'(pwdata[sts_pkg::CNT_W-1:0]) > 32'(TABLE_DEPTH)) begin
        count_r <= sts_pkg::CNT_W'(TABLE_DEPTH);
      end else begin
        count_r <= pwdata[sts_pkg::CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == sts_pkg::REG_ENTRY_COUNT) ?
                  sts_pkg::APB_DW'(count_r) : '0;

  assign in_key       = {in_key_word0, in_key_word1, in_key_word2, in_key_word3};
  assign accept       = start && !busy;
  assign start_lookup = accept && (in_req_type == sts_pkg::REQ_LOOKUP);
  // Loads at or beyond the table depth are dropped.
  assign load_wr      = accept && (in_req_type == sts_pkg::REQ_LOAD) &&
                        (32'(in_entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (start_lookup) begin
      key_r <= in_key;
    end
  end

  sts_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sts_key_cmp u_cmp (
    .entry (rd_data),
    .key   (key_r),
    .res   (cmp)
  );

  sts_search_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_lookup (start_lookup),
    .count        (count_r),
    .cmp          (cmp),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .res          (res)
  );

  assign out_valid       = res.valid;
  assign out_found       = res.found;
  assign out_match_index = res.index;

  // A result is only given once the search has released the block.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while search still busy");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_index == '0))
    else $error("not-found result carries a nonzero index");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_lookup |=> busy)
    else $error("lookup request did not start the search");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule
